// ===== hw/rtl/htlp_pkg.sv =====
package htlp_pkg;

    localparam int TABLE_SLOTS   = 1024;
    localparam int MAX_KEY_BYTES = 8;
    localparam int IDX_W         = $clog2(TABLE_SLOTS);
    localparam int USED_W        = IDX_W + 1;
    localparam int LIMIT_W       = 10;
    localparam bit SLOTS_POW2    = ((1 << IDX_W) == TABLE_SLOTS);

    localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 10'd768;
    localparam logic [31:0]        FNV_OFFSET       = 32'd2166136261;
    localparam logic [31:0]        FNV_PRIME        = 32'd16777619;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_PUT    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_KEY   = 2'd3;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_USED  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_bytes;
        logic [3:0]  key_len;
        logic [63:0] put_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } t_slot;

endpackage

// ===== hw/rtl/hash_table_linear_probe.sv =====
// Steps: one hash step per key byte, then a read and a check per probed slot, then resolve and
// emit; a slot count that is not a power of two adds the reduce state between hashing and the
// first read. Bad keys and the unused action skip hashing and go straight to emit.
// One item at a time: the next beat is taken the cycle after the result is loaded, and the load
// waits while the previous result is still held at the output.
// Reset is synchronous, active low; a clearing pass then empties all slots.
module hash_table_linear_probe
    import htlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req               i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_rsp               o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_HASH    = 8'b0000_0100,
        S_REDUCE  = 8'b0000_1000,
        S_READ    = 8'b0001_0000,
        S_CHECK   = 8'b0010_0000,
        S_RESOLVE = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

    t_slot            mem_slot [TABLE_SLOTS];
    logic [1:0]       mem_mark [TABLE_SLOTS];

    t_state           r_state, n_state;
    t_req             r_req;
    logic [31:0]      r_hash;
    logic [2:0]       r_nb;
    logic [IDX_W:0]   r_rem;
    logic [IDX_W:0]   r_quot;
    logic [1:0]       r_step;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_count;
    logic [IDX_W-1:0] r_tomb;
    logic             r_have_tomb;
    logic             r_have_match;
    logic             r_have_empty;
    logic [IDX_W-1:0] r_clr;
    logic [USED_W-1:0] r_used;
    logic [LIMIT_W-1:0] r_limit;
    t_rsp             r_res;
    t_rsp             r_out;
    logic             r_out_valid;
    t_slot            r_q_slot;
    logic [1:0]       r_q_mark;

    logic             in_fire;
    logic             bad_key;
    logic [63:0]      key_mask;
    logic [7:0]       hash_byte;
    logic [31:0]      hash_next;
    logic             hash_last;
    logic [IDX_W:0]   quot_next;
    logic [IDX_W:0]   rem_prod;
    logic [IDX_W:0]   rem_diff;
    logic [IDX_W:0]   rem_fix;
    logic             slot_match;
    logic [IDX_W-1:0] idx_next;
    logic             out_load;
    logic             mark_we;
    logic [IDX_W-1:0] mark_wa;
    logic [1:0]       mark_wd;
    logic             slot_we;
    logic [IDX_W-1:0] slot_wa;
    t_slot            slot_wd;
    t_rsp             res_next;
    logic             used_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        bad_key = (i_in_data.key_len == 4'd0)
                  || (i_in_data.key_len > 4'(MAX_KEY_BYTES));
        if (i_in_data.key_len >= 4'd8) begin
            key_mask = '1;
        end else begin
            key_mask = (64'd1 << {i_in_data.key_len, 3'b000}) - 64'd1;
        end
    end

    always_comb begin
        hash_byte = r_req.key_bytes[{r_nb, 3'b000} +: 8];
        hash_next = (r_hash ^ {24'd0, hash_byte}) * FNV_PRIME;
        hash_last = ({1'b0, r_nb} + 4'd1) == r_req.key_len;
        quot_next = (IDX_W + 1)'((64'(r_hash) * 64'(RECIP)) >> 32);
        rem_prod  = r_quot * SLOTS_X;
        rem_diff  = r_hash[IDX_W:0] - rem_prod;
        rem_fix   = (r_rem >= SLOTS_X) ? r_rem - SLOTS_X : r_rem;
        idx_next  = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
        slot_match = (r_q_mark == MARK_USED) && (r_q_slot.len == r_req.key_len)
                     && (r_q_slot.key == r_req.key_bytes);
    end

    always_comb begin
        mark_we  = 1'b0;
        mark_wa  = r_idx;
        mark_wd  = MARK_USED;
        slot_we  = 1'b0;
        slot_wa  = r_idx;
        slot_wd  = '{key: r_req.key_bytes, len: r_req.key_len, value: r_req.put_value};
        res_next = '{status: ST_NOT_FOUND, read_value: 64'd0};
        used_inc = 1'b0;
        if (r_state == S_CLEAR) begin
            mark_we = 1'b1;
            mark_wa = r_clr;
            mark_wd = MARK_EMPTY;
        end else if (r_state == S_RESOLVE) begin
            case (r_req.action)
                ACT_GET: begin
                    if (r_have_match) begin
                        res_next = '{status: ST_OK, read_value: r_q_slot.value};
                    end
                end
                ACT_DELETE: begin
                    if (r_have_match) begin
                        mark_we  = 1'b1;
                        mark_wd  = MARK_TOMB;
                        res_next.status = ST_OK;
                    end
                end
                ACT_PUT: begin
                    if (r_have_match) begin
                        slot_we = 1'b1;
                        res_next.status = ST_OK;
                    end else if (r_have_tomb) begin
                        slot_we = 1'b1;
                        slot_wa = r_tomb;
                        mark_we = 1'b1;
                        mark_wa = r_tomb;
                        res_next.status = ST_OK;
                    end else if (r_have_empty
                                 && (r_used + USED_W'(1) <= USED_W'(r_limit))) begin
                        slot_we  = 1'b1;
                        mark_we  = 1'b1;
                        used_inc = 1'b1;
                        res_next.status = ST_OK;
                    end else begin
                        res_next.status = ST_FULL;
                    end
                end
                default: begin
                    res_next.status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mem_mark[mark_wa] <= mark_wd;
        end
        if (slot_we) begin
            mem_slot[slot_wa] <= slot_wd;
        end
        if (r_state == S_READ) begin
            r_q_mark <= mem_mark[r_idx];
            r_q_slot <= mem_slot[r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_clr == LAST_IDX) n_state = S_IDLE;
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (bad_key || i_in_data.action == ACT_NONE) ? S_EMIT : S_HASH;
                end
            end
            S_HASH: begin
                if (hash_last) n_state = SLOTS_POW2 ? S_READ : S_REDUCE;
            end
            S_REDUCE:  if (r_step == 2'd0) n_state = S_READ;
            S_READ:    n_state = S_CHECK;
            S_CHECK: begin
                if (slot_match || (r_q_mark != MARK_USED && r_q_mark != MARK_TOMB)
                    || r_count == LAST_IDX) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RESOLVE: n_state = S_EMIT;
            S_EMIT:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_limit     <= FILL_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (used_inc) begin
                r_used <= r_used + USED_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        case (r_state)
            S_IDLE: begin
                r_req        <= '{action: i_in_data.action,
                                  key_bytes: i_in_data.key_bytes & key_mask,
                                  key_len: i_in_data.key_len,
                                  put_value: i_in_data.put_value};
                r_hash       <= FNV_OFFSET;
                r_nb         <= '0;
                r_rem        <= '0;
                r_step       <= 2'd2;
                r_count      <= '0;
                r_have_tomb  <= 1'b0;
                r_have_match <= 1'b0;
                r_have_empty <= 1'b0;
                r_res <= '{status: bad_key ? ST_BAD_KEY : ST_NOT_FOUND, read_value: 64'd0};
            end
            S_HASH: begin
                r_hash <= hash_next;
                r_nb   <= r_nb + 3'd1;
                r_idx  <= hash_next[IDX_W-1:0];
            end
            S_REDUCE: begin
                r_quot <= quot_next;
                r_rem  <= rem_diff;
                r_idx  <= rem_fix[IDX_W-1:0];
                r_step <= r_step - 2'd1;
            end
            S_CHECK: begin
                if (slot_match) begin
                    r_have_match <= 1'b1;
                end else if (r_q_mark == MARK_TOMB) begin
                    if (!r_have_tomb) begin
                        r_have_tomb <= 1'b1;
                        r_tomb      <= r_idx;
                    end
                    if (r_count != LAST_IDX) begin
                        r_idx   <= idx_next;
                        r_count <= r_count + IDX_W'(1);
                    end
                end else if (r_q_mark != MARK_USED) begin
                    r_have_empty <= 1'b1;
                end else if (r_count != LAST_IDX) begin
                    r_idx   <= idx_next;
                    r_count <= r_count + IDX_W'(1);
                end
            end
            S_RESOLVE: begin
                r_res <= res_next;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(r_state == S_READ))
        else $error("slot checked without a read in the cycle before");

    a_mark_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mark_we |-> (r_state == S_CLEAR || r_state == S_RESOLVE))
        else $error("mark memory written outside clearing or resolve");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_used != $past(r_used))
        |-> ($past(r_state == S_RESOLVE) && r_used == $past(r_used) + USED_W'(1)))
        else $error("used slot count changed other than by one put");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result beat raised outside the emit state");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clearing pass left early");
`endif

endmodule

// ===== dv/hash_table_linear_probe_tb.sv =====
module hash_table_linear_probe_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htlp_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int GAP_LIMIT      = 9;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 200;
    localparam int POOL_SIZE      = 32;
    localparam int PHASE_ITEMS    = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_req               in_data;
    logic               out_valid;
    logic               out_ready;
    t_rsp               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    logic [63:0] tbl_key  [TABLE_SLOTS];
    logic [3:0]  tbl_len  [TABLE_SLOTS];
    logic [63:0] tbl_val  [TABLE_SLOTS];
    logic [1:0]  tbl_mark [TABLE_SLOTS];
    int unsigned used_count;
    int unsigned limit_now;

    logic [63:0] pool_key [POOL_SIZE];
    logic [3:0]  pool_len [POOL_SIZE];

    t_rsp pending_responses[$];

    int gap_max      = GAP_LIMIT;
    int rx_gap_max   = GAP_LIMIT;
    int hold_req     = 0;
    int n_errors     = 0;
    int n_requests   = 0;
    int n_responses  = 0;
    int n_cfg_writes = 0;

    hash_table_linear_probe i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [63:0] key_mask(int unsigned len);
        if (len >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic logic [31:0] fnv_hash(logic [63:0] key, int unsigned len);
        logic [31:0] h;
        h = FNV_OFFSET;
        for (int i = 0; i < len; i++) begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic int unsigned home_slot(logic [63:0] key, int unsigned len);
        return fnv_hash(key, len) % TABLE_SLOTS;
    endfunction

    function automatic t_req mk_req(logic [1:0] act, logic [63:0] key, logic [3:0] len,
                                    logic [63:0] val);
        t_req r;
        r.action     = act;
        r.key_bytes  = key;
        r.key_len    = len;
        r.put_value  = val;
        return r;
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp        rsp;
        logic [63:0] key;
        int unsigned len;
        int unsigned slot;
        int unsigned tomb_slot;
        int unsigned hit_slot;
        int unsigned empty_slot;
        int unsigned target;
        bit          have_tomb;
        bit          have_hit;
        bit          have_empty;
        bit          do_store;
        rsp.status     = ST_NOT_FOUND;
        rsp.read_value = '0;
        len            = r.key_len;
        have_tomb      = 1'b0;
        have_hit       = 1'b0;
        have_empty     = 1'b0;
        do_store       = 1'b0;
        tomb_slot      = 0;
        hit_slot       = 0;
        empty_slot     = 0;
        target         = 0;
        if (len == 0 || len > MAX_KEY_BYTES) begin
            rsp.status = ST_BAD_KEY;
            return rsp;
        end
        if (r.action == ACT_NONE) begin
            return rsp;
        end
        key  = r.key_bytes & key_mask(len);
        slot = home_slot(key, len);
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (tbl_mark[slot] == MARK_USED) begin
                if (tbl_len[slot] == len && tbl_key[slot] == key) begin
                    have_hit = 1'b1;
                    hit_slot = slot;
                    break;
                end
            end else if (tbl_mark[slot] == MARK_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1'b1;
                    tomb_slot = slot;
                end
            end else begin
                have_empty = 1'b1;
                empty_slot = slot;
                break;
            end
            slot = (slot + 1) % TABLE_SLOTS;
        end
        if (r.action == ACT_GET) begin
            if (have_hit) begin
                rsp.status     = ST_OK;
                rsp.read_value = tbl_val[hit_slot];
            end
        end else if (r.action == ACT_DELETE) begin
            if (have_hit) begin
                tbl_mark[hit_slot] = MARK_TOMB;
                rsp.status         = ST_OK;
            end
        end else begin
            if (have_hit) begin
                tbl_val[hit_slot] = r.put_value;
                rsp.status        = ST_OK;
            end else if (have_tomb) begin
                target   = tomb_slot;
                do_store = 1'b1;
            end else if (have_empty && used_count + 1 <= limit_now) begin
                target   = empty_slot;
                do_store = 1'b1;
                used_count++;
            end else begin
                rsp.status = ST_FULL;
            end
            if (do_store) begin
                tbl_key[target]  = key;
                tbl_len[target]  = 4'(len);
                tbl_val[target]  = r.put_value;
                tbl_mark[target] = MARK_USED;
                rsp.status       = ST_OK;
            end
        end
        return rsp;
    endfunction

    function automatic void refresh_key_pool();
        int unsigned len;
        for (int i = 0; i < POOL_SIZE; i++) begin
            len         = $urandom_range(MAX_KEY_BYTES, 1);
            pool_len[i] = 4'(len);
            pool_key[i] = {$urandom, $urandom} & key_mask(len);
        end
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int          roll;
        int          pick;
        logic [63:0] mask;
        roll         = $urandom_range(99, 0);
        pick         = $urandom_range(POOL_SIZE - 1, 0);
        r.key_bytes  = pool_key[pick];
        r.key_len    = pool_len[pick];
        r.put_value  = {$urandom, $urandom};
        if (roll < 45) begin
            r.action = ACT_PUT;
        end else if (roll < 80) begin
            r.action = ACT_GET;
        end else if (roll < 92) begin
            r.action = ACT_DELETE;
        end else begin
            r.action    = 2'($urandom_range(3, 0));
            r.key_bytes = {$urandom, $urandom};
            case ($urandom_range(2, 0))
                0: begin
                    r.key_len = 4'($urandom_range(15, 0));
                end
                1: begin
                    r.action  = ACT_NONE;
                    r.key_len = 4'($urandom_range(MAX_KEY_BYTES, 1));
                end
                default: begin
                    r.key_len = 4'($urandom_range(MAX_KEY_BYTES, 1));
                end
            endcase
            return r;
        end
        if ($urandom_range(1, 0) == 1) begin
            mask        = key_mask(r.key_len);
            r.key_bytes = (r.key_bytes & mask) | ({$urandom, $urandom} & ~mask);
        end
        return r;
    endfunction

    task automatic push_request(input t_req r);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_responses.push_back(apply_request(r));
        n_requests++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_fill_limit(input logic [LIMIT_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        limit_now = value;
        n_cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_operations();
        push_request(mk_req(ACT_GET, 64'h0000_0000_00ab_cdef, 4'd3, 64'd0));
        push_request(mk_req(ACT_PUT, '1, 4'd8, '1));
        push_request(mk_req(ACT_GET, '1, 4'd8, 64'd0));
        push_request(mk_req(ACT_PUT, '1, 4'd8, 64'd0));
        push_request(mk_req(ACT_GET, '1, 4'd8, '1));
        push_request(mk_req(ACT_PUT, 64'hffff_ffff_ffff_ff00, 4'd1, 64'h0123_4567_89ab_cdef));
        push_request(mk_req(ACT_GET, 64'h0000_0000_0000_0000, 4'd1, 64'd0));
        push_request(mk_req(ACT_GET, 64'h0000_0000_0000_0000, 4'd2, 64'd0));
        push_request(mk_req(ACT_DELETE, 64'h5a5a_5a5a_5a5a_5a00, 4'd1, 64'd0));
        push_request(mk_req(ACT_GET, 64'h0000_0000_0000_0000, 4'd1, 64'd0));
        push_request(mk_req(ACT_DELETE, 64'h0000_0000_0000_0000, 4'd1, 64'd0));
        push_request(mk_req(ACT_PUT, 64'h0000_0000_0000_0000, 4'd1, 64'h8000_0000_0000_0001));
        push_request(mk_req(ACT_GET, 64'h1234_0000_0000_0000, 4'd1, 64'd0));
        push_request(mk_req(ACT_PUT, '1, 4'd0, '1));
        push_request(mk_req(ACT_GET, '1, 4'd9, 64'd0));
        push_request(mk_req(ACT_DELETE, '1, 4'd15, 64'd0));
        push_request(mk_req(ACT_NONE, 64'h0000_0000_dead_beef, 4'd4, '1));
        push_request(mk_req(ACT_NONE, '1, 4'd0, '1));
    endtask

    task automatic test_probe_chain();
        logic [63:0] ka;
        logic [63:0] kb;
        int          found;
        ka    = '0;
        kb    = '0;
        found = 0;
        // Two keys homed on the last slot: the second wraps around to slot zero.
        for (int k = 0; k < 65536 && found < 2; k++) begin
            if (home_slot(64'(k), 2) == TABLE_SLOTS - 1) begin
                if (found == 0) begin
                    ka = 64'(k);
                end else begin
                    kb = 64'(k);
                end
                found++;
            end
        end
        push_request(mk_req(ACT_PUT, ka, 4'd2, 64'h0000_0000_0000_00aa));
        push_request(mk_req(ACT_PUT, kb, 4'd2, 64'h0000_0000_0000_00bb));
        push_request(mk_req(ACT_DELETE, ka, 4'd2, 64'd0));
        push_request(mk_req(ACT_GET, kb, 4'd2, 64'd0));
        push_request(mk_req(ACT_PUT, kb, 4'd2, 64'h0000_0000_0000_00cc));
        push_request(mk_req(ACT_GET, kb, 4'd2, 64'd0));
        push_request(mk_req(ACT_PUT, ka, 4'd2, 64'h0000_0000_0000_00dd));
        push_request(mk_req(ACT_GET, ka, 4'd2, 64'd0));
    endtask

    task automatic test_fill_limit();
        logic [63:0] fresh [6];
        write_fill_limit(LIMIT_W'(used_count + 3));
        for (int i = 0; i < 6; i++) begin
            fresh[i] = {$urandom, $urandom};
            push_request(mk_req(ACT_PUT, fresh[i], 4'd8, {$urandom, $urandom}));
        end
        push_request(mk_req(ACT_PUT, fresh[0], 4'd8, {$urandom, $urandom}));
        push_request(mk_req(ACT_DELETE, fresh[1], 4'd8, 64'd0));
        push_request(mk_req(ACT_PUT, fresh[1], 4'd8, {$urandom, $urandom}));
        for (int i = 0; i < 3; i++) begin
            push_request(mk_req(ACT_GET, fresh[i], 4'd8, 64'd0));
        end
        write_fill_limit(LIMIT_W'(1));
        push_request(mk_req(ACT_PUT, {$urandom, $urandom}, 4'd8, {$urandom, $urandom}));
        push_request(mk_req(ACT_PUT, fresh[2], 4'd8, {$urandom, $urandom}));
        write_fill_limit(LIMIT_W'(1023));
    endtask

    task automatic test_backpressure();
        refresh_key_pool();
        hold_req <= hold_req + 1;
        gap_max = 0;
        repeat (24) push_request(random_request());
        gap_max = GAP_LIMIT;
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        int unsigned new_limit;
        for (int p = 0; p < 4; p++) begin
            refresh_key_pool();
            case (p)
                0: new_limit = 1023;
                1: new_limit = $urandom_range(1023, 300);
                2: new_limit = (used_count + 12 > 1023) ? 1023 : used_count + 12;
                default: new_limit = FILL_LIMIT_RESET;
            endcase
            write_fill_limit(LIMIT_W'(new_limit));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 100 == 0) begin
                    gap_max    = ($urandom_range(3, 0) == 0) ? 0 : GAP_LIMIT;
                    rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : GAP_LIMIT;
                end
                push_request(random_request());
            end
        end
        gap_max    = GAP_LIMIT;
        rx_gap_max = GAP_LIMIT;
    endtask

    // Check each response beat against the oldest prediction.
    initial begin
        int   stall;
        int   hold_left;
        int   hold_seen;
        t_rsp want;
        out_ready = 1'b0;
        stall     = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                n_responses++;
                if (pending_responses.size() == 0) begin
                    $display("%0t: response with nothing outstanding, status %0d value %h",
                             $time, out_data.status, out_data.read_value);
                    n_errors++;
                end else begin
                    want = pending_responses.pop_front();
                    if (out_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_data.status);
                        n_errors++;
                    end
                    if (out_data.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.read_value, out_data.read_value);
                        n_errors++;
                    end
                end
                stall = $urandom_range(rx_gap_max, 0);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_key[i]  = '0;
            tbl_len[i]  = '0;
            tbl_val[i]  = '0;
            tbl_mark[i] = MARK_EMPTY;
        end
        used_count = 0;
        limit_now  = FILL_LIMIT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_operations();
        test_probe_chain();
        test_fill_limit();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();

        $display("Run covered %0d requests and %0d responses over %0d fill limit writes,",
                 n_requests, n_responses, n_cfg_writes);
        $display("with probe wraparound, tombstones, refused puts, long stalls and random mixes.");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
